// ----- sv/mpct_pkg.sv -----
`timescale 1ns / 1ps

package mpct_pkg;

  localparam int POS_W  = 11;
  localparam int MAG_W  = 9;
  localparam int BYTE_W = 8;
  localparam int TRK_W  = 2;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  // Register indexes (paddr[2])
  localparam logic REG_X_LIMIT = 1'b0;
  localparam logic REG_Y_LIMIT = 1'b1;

  localparam logic [POS_W-1:0] X_LIMIT_RST = POS_W'(1024);
  localparam logic [POS_W-1:0] Y_LIMIT_RST = POS_W'(768);

  // Button tracker codes
  localparam logic [TRK_W-1:0] TRK_UP    = 2'd0;
  localparam logic [TRK_W-1:0] TRK_CLICK = 2'd1;
  localparam logic [TRK_W-1:0] TRK_DOWN  = 2'd2;
  localparam logic [TRK_W-1:0] TRK_RSVD  = 2'd3;

  // Status byte bit positions
  localparam int ST_LEFT  = 0;
  localparam int ST_RIGHT = 1;
  localparam int ST_XSIGN = 4;
  localparam int ST_YSIGN = 5;

  // Decoded packet, as it sits in the queue
  typedef struct packed {
    logic [MAG_W-1:0] mag_x;
    logic             grow_x;
    logic [MAG_W-1:0] mag_y;
    logic             grow_y;
    logic             btn_l;
    logic             btn_r;
  } pkt_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    pkt_t pkt;
  } q_head_t;

endpackage

// ----- sv/mpct_if.sv -----
`timescale 1ns / 1ps

interface mpct_in_if;
  import mpct_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] status_byte;
  logic [BYTE_W-1:0] x_byte;
  logic [BYTE_W-1:0] y_byte;

  modport source (output valid, output status_byte, output x_byte, output y_byte,
                  input ready);
  modport sink   (input valid, input status_byte, input x_byte, input y_byte,
                  output ready);
endinterface

interface mpct_out_if;
  import mpct_pkg::*;

  logic             valid;
  logic             ready;
  logic [POS_W-1:0] cursor_x;
  logic [POS_W-1:0] cursor_y;
  logic [TRK_W-1:0] left_state;
  logic [TRK_W-1:0] right_state;

  modport source (output valid, output cursor_x, output cursor_y,
                  output left_state, output right_state, input ready);
  modport sink   (input valid, input cursor_x, input cursor_y,
                  input left_state, input right_state, output ready);
endinterface

// ----- sv/mpct_front.sv -----
`timescale 1ns / 1ps

module mpct_front (
  mpct_in_if.sink          in_ch,
  input  logic             q_full,
  output logic             push,
  output mpct_pkg::pkt_t   push_pkt
);
  import mpct_pkg::*;

  logic xs;
  logic ys;

  assign xs = in_ch.status_byte[ST_XSIGN];
  assign ys = in_ch.status_byte[ST_YSIGN];

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  // Sign-extended byte -> magnitude; negative zero byte means 256
  always_comb begin
    push_pkt.mag_x  = xs ? ({1'b0, ~in_ch.x_byte} + MAG_W'(1)) : {1'b0, in_ch.x_byte};
    push_pkt.mag_y  = ys ? ({1'b0, ~in_ch.y_byte} + MAG_W'(1)) : {1'b0, in_ch.y_byte};
    push_pkt.grow_x = !xs;
    push_pkt.grow_y = ys;   // screen Y: negative packet Y moves down
    push_pkt.btn_l  = in_ch.status_byte[ST_LEFT];
    push_pkt.btn_r  = in_ch.status_byte[ST_RIGHT];
  end

endmodule

// ----- sv/mpct_queue.sv -----
`timescale 1ns / 1ps

module mpct_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mpct_pkg::pkt_t    push_pkt,
  output logic              full,
  input  logic              pop,
  output mpct_pkg::q_head_t head
);
  import mpct_pkg::*;

  pkt_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r,  count_nxt;

  assign full       = (count_r == (QPTR_W+1)'(QDEPTH));
  assign head.valid = (count_r != '0);
  assign head.pkt   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_pkt;
    end
  end

endmodule

// ----- sv/mpct_back.sv -----
`timescale 1ns / 1ps

module mpct_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mpct_pkg::q_head_t            head,
  output logic                         pop,
  input  logic [mpct_pkg::POS_W-1:0]   x_limit,
  input  logic [mpct_pkg::POS_W-1:0]   y_limit,
  mpct_out_if.source                   out_ch
);
  import mpct_pkg::*;

  function automatic logic [TRK_W-1:0] next_track(logic [TRK_W-1:0] cur, logic pressed);
    logic [TRK_W-1:0] t;
    if (!pressed)          t = TRK_UP;
    else if (cur == TRK_UP) t = TRK_CLICK;
    else                   t = TRK_DOWN;
    return t;
  endfunction

  // Move, floor at zero or add, then cap at limit
  function automatic logic [POS_W-1:0] move_axis(logic [POS_W-1:0] pos,
                                                 logic [MAG_W-1:0] mag,
                                                 logic grow,
                                                 logic [POS_W-1:0] limit);
    logic [POS_W:0] p;
    logic [POS_W:0] m;
    logic [POS_W:0] r;
    p = {1'b0, pos};
    m = (POS_W+1)'(mag);
    if (grow)        r = p + m;
    else if (m >= p) r = '0;
    else             r = p - m;
    if (r > {1'b0, limit}) r = {1'b0, limit};
    return r[POS_W-1:0];
  endfunction

  logic [POS_W-1:0] pos_x_r, pos_x_nxt;
  logic [POS_W-1:0] pos_y_r, pos_y_nxt;
  logic [TRK_W-1:0] left_r,  left_nxt;
  logic [TRK_W-1:0] right_r, right_nxt;
  logic             out_valid_r;
  logic [POS_W-1:0] out_x_r, out_y_r;
  logic [TRK_W-1:0] out_l_r, out_rt_r;

  assign pop = head.valid && (!out_valid_r || out_ch.ready);

  assign pos_x_nxt = move_axis(pos_x_r, head.pkt.mag_x, head.pkt.grow_x, x_limit);
  assign pos_y_nxt = move_axis(pos_y_r, head.pkt.mag_y, head.pkt.grow_y, y_limit);
  assign left_nxt  = next_track(left_r,  head.pkt.btn_l);
  assign right_nxt = next_track(right_r, head.pkt.btn_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      left_r      <= TRK_UP;
      right_r     <= TRK_UP;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        pos_x_r     <= pos_x_nxt;
        pos_y_r     <= pos_y_nxt;
        left_r      <= left_nxt;
        right_r     <= right_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_x_r  <= pos_x_nxt;
      out_y_r  <= pos_y_nxt;
      out_l_r  <= left_nxt;
      out_rt_r <= right_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.cursor_x    = out_x_r;
  assign out_ch.cursor_y    = out_y_r;
  assign out_ch.left_state  = out_l_r;
  assign out_ch.right_state = out_rt_r;

endmodule

// ----- sv/mouse_packet_cursor_tracker_unit.sv -----
`timescale 1ns / 1ps
// Channel  | Dir | Handshake            | Payload
// ---------+-----+----------------------+-------------------------------------------
// in_ch    | in  | valid/ready          | status_byte, x_byte, y_byte
// out_ch   | out | valid/ready          | cursor_x, cursor_y, left_state, right_state
// APB cfg  | in  | psel/penable, pready | x_limit @0x0, y_limit @0x4 (11 bits each)
//
// One packet per cycle sustained while out_ch is ready. A packet accepted on in_ch is
// decoded into the 2-entry queue, then popped into the result register before it
// reaches out_ch; the back end updates cursor and trackers once per packet.
// Reset (rst_n low, synchronous) clears cursor to 0,0, trackers to up, the
// queue, and loads limits 1024/768. A stalled out_ch holds the result register
// while the queue keeps taking up to two more packets.

module mouse_packet_cursor_tracker_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  mpct_in_if.sink                           in_ch,
  mpct_out_if.source                        out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mpct_pkg::APB_AW-1:0]       paddr,
  input  logic [mpct_pkg::APB_DW-1:0]       pwdata,
  output logic [mpct_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);
  import mpct_pkg::*;

  logic [POS_W-1:0] x_limit_r;
  logic [POS_W-1:0] y_limit_r;
  logic             cfg_wr;

  logic    q_push;
  logic    q_full;
  logic    q_pop;
  pkt_t    q_push_pkt;
  q_head_t q_head;

  // ---------------- configuration registers ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_limit_r <= X_LIMIT_RST;
      y_limit_r <= Y_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_X_LIMIT: x_limit_r <= pwdata[POS_W-1:0];
        REG_Y_LIMIT: y_limit_r <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_X_LIMIT: prdata = APB_DW'(x_limit_r);
      REG_Y_LIMIT: prdata = APB_DW'(y_limit_r);
      default:     prdata = '0;
    endcase
  end

  // ---------------- front: accept and decode ----------------
  mpct_front u_front (
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (q_push),
    .push_pkt (q_push_pkt)
  );

  // ---------------- decoupling queue ----------------
  mpct_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_pkt (q_push_pkt),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head)
  );

  // ---------------- back: cursor/tracker update + result reg ----------------
  mpct_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (q_head),
    .pop     (q_pop),
    .x_limit (x_limit_r),
    .y_limit (y_limit_r),
    .out_ch  (out_ch)
  );

  // ---------------- assertions ----------------
  a_reset_no_result: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  a_pop_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_ch.valid)
    else $error("queue pop did not produce a result");

  a_tracker_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.left_state != TRK_RSVD) && (out_ch.right_state != TRK_RSVD))
    else $error("tracker reached reserved code");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full && !q_pop |=> q_full || !$past(q_push))
    else $error("queue overflow");

endmodule

// ----- sim/mouse_packet_cursor_tracker_unit_tb.sv -----
`timescale 1ns / 1ps

module mouse_packet_cursor_tracker_unit_tb;
  import mpct_pkg::*;

  // Run length and guard limits
  localparam int ITEMS_PER_SEG = 305;     // six random segments after the table
  localparam int NUM_SEGS      = 6;
  localparam int LONG_STALL    = 64;      // receiver hold-off, in cycles
  localparam int DRAIN_CYCLES  = 16;      // quiet time after the last result
  localparam int CYCLE_LIMIT   = 200000;

  // One cursor report as seen on out_ch
  typedef struct packed {
    logic [POS_W-1:0] cursor_x;
    logic [POS_W-1:0] cursor_y;
    logic [TRK_W-1:0] left_state;
    logic [TRK_W-1:0] right_state;
  } cursor_rpt_t;

  // Directed table: a packet row, or a limit register write
  typedef enum logic {ROW_PKT, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic              reg_idx;
    logic [POS_W-1:0]  lim;
    logic [BYTE_W-1:0] st;
    logic [BYTE_W-1:0] xb;
    logic [BYTE_W-1:0] yb;
    logic              typed;     // want holds a hand-written expectation
    cursor_rpt_t       want;
  } row_t;

  localparam int N_ROWS = 27;

  // After reset the limits are 1024 x 768 and the cursor sits at 0,0.
  // Typed expectations only where the result is obvious; the rest go
  // through the predictor.
  row_t directed_rows [N_ROWS] = '{
    // status bit 3 set (always set on a real link), no movement
    '{ROW_PKT, 1'b0, 11'd0, 8'h08, 8'h00, 8'h00, 1'b1, '{11'd0,    11'd0,   TRK_UP,    TRK_UP}},
    // largest positive X
    '{ROW_PKT, 1'b0, 11'd0, 8'h00, 8'hFF, 8'h00, 1'b1, '{11'd255,  11'd0,   TRK_UP,    TRK_UP}},
    // X sign with byte 0 is -256: floors at zero
    '{ROW_PKT, 1'b0, 11'd0, 8'h10, 8'h00, 8'h00, 1'b1, '{11'd0,    11'd0,   TRK_UP,    TRK_UP}},
    // Y sign with byte 0: cursor moves down by 256, three times, up to the limit
    '{ROW_PKT, 1'b0, 11'd0, 8'h20, 8'h00, 8'h00, 1'b1, '{11'd0,    11'd256, TRK_UP,    TRK_UP}},
    '{ROW_PKT, 1'b0, 11'd0, 8'h20, 8'h00, 8'h00, 1'b1, '{11'd0,    11'd512, TRK_UP,    TRK_UP}},
    '{ROW_PKT, 1'b0, 11'd0, 8'h20, 8'h00, 8'h00, 1'b1, '{11'd0,    11'd768, TRK_UP,    TRK_UP}},
    // smallest negative Y (-1) on top of the limit: saturates
    '{ROW_PKT, 1'b0, 11'd0, 8'h20, 8'h01, 8'hFF, 1'b1, '{11'd1,    11'd768, TRK_UP,    TRK_UP}},
    // positive Y moves the cursor up
    '{ROW_PKT, 1'b0, 11'd0, 8'h00, 8'h00, 8'hFF, 1'b1, '{11'd1,    11'd513, TRK_UP,    TRK_UP}},
    // button tracker walk: up -> click -> down, release -> up
    '{ROW_PKT, 1'b0, 11'd0, 8'h01, 8'h00, 8'h00, 1'b1, '{11'd1,    11'd513, TRK_CLICK, TRK_UP}},
    '{ROW_PKT, 1'b0, 11'd0, 8'h03, 8'h00, 8'h00, 1'b1, '{11'd1,    11'd513, TRK_DOWN,  TRK_CLICK}},
    '{ROW_PKT, 1'b0, 11'd0, 8'h03, 8'h00, 8'h00, 1'b1, '{11'd1,    11'd513, TRK_DOWN,  TRK_DOWN}},
    '{ROW_PKT, 1'b0, 11'd0, 8'h02, 8'h00, 8'h00, 1'b1, '{11'd1,    11'd513, TRK_UP,    TRK_DOWN}},
    // ignored status bits (2, 3, 6, 7) all set, buttons released
    '{ROW_PKT, 1'b0, 11'd0, 8'hCC, 8'h00, 8'h00, 1'b1, '{11'd1,    11'd513, TRK_UP,    TRK_UP}},
    // run X into the default limit
    '{ROW_PKT, 1'b0, 11'd0, 8'h00, 8'hFF, 8'h00, 1'b0, '0},
    '{ROW_PKT, 1'b0, 11'd0, 8'h00, 8'hFF, 8'h00, 1'b0, '0},
    '{ROW_PKT, 1'b0, 11'd0, 8'h00, 8'hFF, 8'h00, 1'b0, '0},
    '{ROW_PKT, 1'b0, 11'd0, 8'h00, 8'hFF, 8'h00, 1'b0, '0},
    '{ROW_PKT, 1'b0, 11'd0, 8'h00, 8'hFF, 8'h00, 1'b1, '{11'd1024, 11'd513, TRK_UP,    TRK_UP}},
    // widest limits
    '{ROW_CFG, REG_X_LIMIT, 11'd2047, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{ROW_CFG, REG_Y_LIMIT, 11'd2047, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{ROW_PKT, 1'b0, 11'd0, 8'h00, 8'hFF, 8'h00, 1'b0, '0},
    '{ROW_PKT, 1'b0, 11'd0, 8'h20, 8'h7F, 8'h80, 1'b0, '0},
    '{ROW_PKT, 1'b0, 11'd0, 8'h1D, 8'h80, 8'h7F, 1'b0, '0},
    // narrowest limits, well below the current position: the next packet is
    // capped even though it moves the cursor toward the origin
    '{ROW_CFG, REG_X_LIMIT, 11'd1,    8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{ROW_CFG, REG_Y_LIMIT, 11'd1,    8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{ROW_PKT, 1'b0, 11'd0, 8'h10, 8'hFF, 8'hFF, 1'b1, '{11'd1,    11'd1,   TRK_UP,    TRK_UP}},
    '{ROW_PKT, 1'b0, 11'd0, 8'h00, 8'h00, 8'hFF, 1'b1, '{11'd1,    11'd0,   TRK_UP,    TRK_UP}}
  };

  logic clk;
  logic rst_n;

  // APB-style config port
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  mpct_in_if  in_ch_if ();
  mpct_out_if out_ch_if ();

  mouse_packet_cursor_tracker_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch_if),
    .out_ch  (out_ch_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Cursor predictor: its own copy of position, trackers and limits.
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0] cur_x, cur_y;
  logic [POS_W-1:0] lim_x, lim_y;
  logic [TRK_W-1:0] btn_l_state, btn_r_state;

  cursor_rpt_t pending_reports [$];   // expected reports, oldest first
  int          mismatch_cnt;

  // Sidecar for the packet currently driven: a hand-written expectation
  logic        drv_typed;
  cursor_rpt_t drv_want;

  // Idle rates (percent) and the long receiver hold-off request
  int send_idle_pct;
  int recv_idle_pct;
  bit long_stall_req;

  function automatic logic [TRK_W-1:0] next_btn_state(input logic [TRK_W-1:0] cur,
                                                      input logic pressed);
    if (!pressed) return TRK_UP;
    if (cur == TRK_UP) return TRK_CLICK;
    return TRK_DOWN;   // click, down and the unused code all go to down
  endfunction

  // Move by mag (toward the limit when grow is set), floor at 0, then cap at
  // the limit regardless of direction.
  function automatic logic [POS_W-1:0] step_axis(input logic [POS_W-1:0] pos,
                                                 input int unsigned mag,
                                                 input logic grow,
                                                 input logic [POS_W-1:0] lim);
    int unsigned r;
    if (grow) r = pos + mag;
    else      r = (mag >= pos) ? 0 : pos - mag;
    if (r > lim) r = lim;
    return POS_W'(r);
  endfunction

  function automatic cursor_rpt_t advance_cursor(input logic [BYTE_W-1:0] st,
                                                 input logic [BYTE_W-1:0] xb,
                                                 input logic [BYTE_W-1:0] yb);
    int unsigned mag_x, mag_y;
    // sign bit makes the byte a 9-bit negative: magnitude 1..256
    mag_x = st[ST_XSIGN] ? 256 - int'(xb) : int'(xb);
    mag_y = st[ST_YSIGN] ? 256 - int'(yb) : int'(yb);
    btn_r_state = next_btn_state(btn_r_state, st[ST_RIGHT]);
    btn_l_state = next_btn_state(btn_l_state, st[ST_LEFT]);
    cur_x = step_axis(cur_x, mag_x, !st[ST_XSIGN], lim_x);
    // screen Y: a negative packet Y moves the cursor down (larger Y)
    cur_y = step_axis(cur_y, mag_y, st[ST_YSIGN], lim_y);
    return '{cur_x, cur_y, btn_l_state, btn_r_state};
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard. Input transactions are predicted before output transactions
  // of the same edge are checked, so latency does not matter.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cursor_rpt_t pred;
    cursor_rpt_t got;
    cursor_rpt_t exp_rpt;
    if (rst_n && in_ch_if.valid && in_ch_if.ready) begin
      pred = advance_cursor(in_ch_if.status_byte, in_ch_if.x_byte, in_ch_if.y_byte);
      pending_reports.push_back(drv_typed ? drv_want : pred);
    end
    if (rst_n && out_ch_if.valid && out_ch_if.ready) begin
      got = '{out_ch_if.cursor_x, out_ch_if.cursor_y,
              out_ch_if.left_state, out_ch_if.right_state};
      if (pending_reports.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected report x=%0d y=%0d l=%0d r=%0d",
                   got.cursor_x, got.cursor_y, got.left_state, got.right_state);
      end else begin
        exp_rpt = pending_reports.pop_front();
        if (got !== exp_rpt) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("report mismatch: exp x=%0d y=%0d l=%0d r=%0d, got x=%0d y=%0d l=%0d r=%0d",
                     exp_rpt.cursor_x, exp_rpt.cursor_y, exp_rpt.left_state,
                     exp_rpt.right_state, got.cursor_x, got.cursor_y,
                     got.left_state, got.right_state);
        end
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request so the
  // 2-entry queue fills and in_ch.ready drops.
  always @(negedge clk) begin
    int  stall_left;
    bit  stall_taken;
    if (long_stall_req && !stall_taken) begin
      stall_taken = 1'b1;
      stall_left  = LONG_STALL;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ch_if.ready <= 1'b0;
    end else begin
      out_ch_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    int cycle_cnt;
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one packet (after optional idle cycles) and hold it until accepted.
  // Returns on the accepting rising edge.
  task automatic send_packet(input logic [BYTE_W-1:0] st, input logic [BYTE_W-1:0] xb,
                             input logic [BYTE_W-1:0] yb, input logic typed,
                             input cursor_rpt_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch_if.valid       <= 1'b1;
    in_ch_if.status_byte <= st;
    in_ch_if.x_byte      <= xb;
    in_ch_if.y_byte      <= yb;
    drv_typed            <= typed;
    drv_want             <= want;
    do @(posedge clk); while (!in_ch_if.ready);
  endtask

  // Drop valid and wait until every expected report has come back. One
  // report per packet, so an empty queue means the block is idle.
  task automatic wait_drained();
    @(negedge clk);
    in_ch_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // APB write of a limit register, then read it back.
  task automatic write_limit(input logic reg_idx, input logic [POS_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({reg_idx, 2'b00});
    pwdata  <= APB_DW'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_idx == REG_X_LIMIT) lim_x = value;
    else                        lim_y = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[POS_W-1:0] !== value) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("limit readback mismatch: reg %0d exp %0d, got %0d",
                 reg_idx, value, prdata[POS_W-1:0]);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Limits for a random segment: mostly small so saturation is common
  function automatic logic [POS_W-1:0] pick_limit();
    case ($urandom_range(0, 3))
      0:       return POS_W'($urandom_range(1, 2047));
      1:       return POS_W'($urandom_range(1, 64));
      2:       return POS_W'($urandom_range(200, 900));
      default: return $urandom_range(0, 1) ? 11'd2047 : 11'd1;
    endcase
  endfunction

  // Movement byte: corners (0, 0xFF, 0x80), small steps and full range
  function automatic logic [BYTE_W-1:0] pick_move_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return BYTE_W'($urandom_range(0, 15));
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int                seg;
    int                n;
    logic [1:0]        held_btns;
    logic [BYTE_W-1:0] st, xb, yb;

    // known values on every input from time zero
    rst_n                = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_ch_if.valid       = 1'b0;
    in_ch_if.status_byte = '0;
    in_ch_if.x_byte      = '0;
    in_ch_if.y_byte      = '0;
    out_ch_if.ready      = 1'b0;
    drv_typed            = 1'b0;
    drv_want             = '0;
    send_idle_pct        = 0;
    recv_idle_pct        = 0;
    long_stall_req       = 1'b0;
    mismatch_cnt         = 0;
    held_btns            = 2'b00;

    // predictor reset state
    cur_x       = '0;
    cur_y       = '0;
    lim_x       = X_LIMIT_RST;
    lim_y       = Y_LIMIT_RST;
    btn_l_state = TRK_UP;
    btn_r_state = TRK_UP;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table, light back-pressure on both sides
    send_idle_pct = 10;
    recv_idle_pct = 20;
    for (int i = 0; i < N_ROWS; i++) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_drained();
        write_limit(directed_rows[i].reg_idx, directed_rows[i].lim);
      end else begin
        send_packet(directed_rows[i].st, directed_rows[i].xb, directed_rows[i].yb,
                    directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random segments, two per idle mode: sender 12 / receiver 70, then the
    // reverse, then no idling. New limits at the start of every segment.
    for (seg = 0; seg < NUM_SEGS; seg++) begin
      wait_drained();
      case (seg / 2)
        0:       begin send_idle_pct = 12; recv_idle_pct = 70; end
        1:       begin send_idle_pct = 70; recv_idle_pct = 12; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      write_limit(REG_X_LIMIT, pick_limit());
      write_limit(REG_Y_LIMIT, pick_limit());
      // long receiver hold-off while the sender streams back to back
      if (seg == 4) long_stall_req = 1'b1;
      for (n = 0; n < ITEMS_PER_SEG; n++) begin
        // buttons tend to stay put for a few packets so trackers reach down
        if ($urandom_range(0, 3) == 0) held_btns = 2'($urandom);
        st            = BYTE_W'($urandom);
        st[ST_LEFT]   = held_btns[0];
        st[ST_RIGHT]  = held_btns[1];
        xb            = pick_move_byte();
        yb            = pick_move_byte();
        send_packet(st, xb, yb, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
